// ----- rtl/psu_pkg.sv -----
// Shared types and constants for the PNG scanline unfilter.
`default_nettype none

package psu_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BPP       = 2'd0;
    localparam logic [1:0] CFG_ROW_BYTES = 2'd1;
    localparam logic [1:0] CFG_ROW_COUNT = 2'd2;

    localparam int BPP_W   = 3;
    localparam int COL_W   = 14;
    localparam int ROW_W   = 16;
    localparam int CFG_W   = 16;
    localparam int BYTE_W  = 8;

    // PNG filter type codes.
    localparam logic [7:0] PNG_FILTER_NONE  = 8'd0;
    localparam logic [7:0] PNG_FILTER_SUB   = 8'd1;
    localparam logic [7:0] PNG_FILTER_UP    = 8'd2;
    localparam logic [7:0] PNG_FILTER_AVG   = 8'd3;
    localparam logic [7:0] PNG_FILTER_PAETH = 8'd4;

    typedef enum logic [2:0] {
        FLT_NONE,
        FLT_SUB,
        FLT_UP,
        FLT_AVG,
        FLT_PAETH
    } t_filter;

    // Pixel word travelling from the read stage to the compute stage.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        t_filter           filter;
        logic              has_left;
        logic              has_upper;
        logic [1:0]        stride_sel;
        logic              row_end;
        logic              image_end;
    } t_pix_word;

    function automatic logic [BYTE_W-1:0] paeth_pred(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] c
    );
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        logic        [10:0] pa;
        logic        [10:0] pb;
        logic        [10:0] pc;
        logic [BYTE_W-1:0]  res;
        // p - a = b - c, p - b = a - c, p - c = a + b - 2c
        da = $signed({3'b000, b}) - $signed({3'b000, c});
        db = $signed({3'b000, a}) - $signed({3'b000, c});
        dc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
        pa = (da < 0) ? 11'(-da) : 11'(da);
        pb = (db < 0) ? 11'(-db) : 11'(db);
        pc = (dc < 0) ? 11'(-dc) : 11'(dc);
        if (pa <= pb && pa <= pc) begin
            res = a;
        end else if (pb <= pc) begin
            res = b;
        end else begin
            res = c;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/png_scanline_unfilter.sv -----
// PNG scanline unfilter: filter reconstruction over a one-row line store.
//
// The input channel takes the decompressed stream one word per cycle while
// o_stall is low. The first word of each row is the filter type and yields no
// output word; every following word is a filtered pixel byte and yields one
// reconstructed byte on the output channel, flagged with row_end and image_end.
// Configuration words (bytes per pixel, row length, row count) arrive on a
// separate write channel that is always ready; write them only while no
// pixel is in flight.
// A pixel byte passes from the compute-stage register into the output register,
// where the receiver can take it; the compute stage holds it while the output stalls.
// Throughput: one word per cycle unless both stages are full. The line store
// is read when a pixel is accepted and written when it is reconstructed; a read
// and a write of the same column in one cycle are resolved by forwarding.
// Reset clears the configuration to 4 bytes per pixel, 8192-byte rows and a
// single-row image, and expects a filter byte next. The line store is not
// cleared; the first row never reads it.
// When the receiver stalls, the output word holds; input is still taken
// while the compute stage is empty, and is stalled once both stages are full.
`default_nettype none

module png_scanline_unfilter
    import psu_pkg::*;
#(
    parameter int MAX_ROW_BYTES = 8192
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [BYTE_W-1:0]  i_data_byte,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [BYTE_W-1:0]       o_pixel_byte,
    output logic                    o_row_end,
    output logic                    o_image_end,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data
);

    localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int ColMax = (1 << COL_W) - 1;
    localparam int RbCapI = (MAX_ROW_BYTES < ColMax) ? MAX_ROW_BYTES : ColMax;
    localparam logic [COL_W-1:0] RbCap = COL_W'(RbCapI);

    // Configuration
    logic [BPP_W-1:0] r_bpp;
    logic [COL_W-1:0] r_row_bytes;
    logic [ROW_W-1:0] r_row_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp       <= BPP_W'(4);
            r_row_bytes <= COL_W'(8192);
            r_row_count <= ROW_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BPP:       r_bpp       <= i_cfg_data[BPP_W-1:0];
                CFG_ROW_BYTES: r_row_bytes <= i_cfg_data[COL_W-1:0];
                CFG_ROW_COUNT: r_row_count <= i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective configuration values
    logic [BPP_W-1:0] bpp_eff;
    logic [COL_W-1:0] rb_eff;
    logic [ROW_W-1:0] rc_eff;

    always_comb begin
        if (r_bpp == '0) begin
            bpp_eff = BPP_W'(1);
        end else if (r_bpp > BPP_W'(4)) begin
            bpp_eff = BPP_W'(4);
        end else begin
            bpp_eff = r_bpp;
        end
        if (r_row_bytes == '0) begin
            rb_eff = COL_W'(1);
        end else if (r_row_bytes > RbCap) begin
            rb_eff = RbCap;
        end else begin
            rb_eff = r_row_bytes;
        end
        rc_eff = (r_row_count == '0) ? ROW_W'(1) : r_row_count;
    end

    // Pipeline handshake
    logic r_s1_valid;
    logic r_out_valid;
    logic out_free;
    logic s1_free;
    logic s1_adv;
    logic accept;

    assign out_free = !r_out_valid || !i_stall;
    assign s1_adv   = r_s1_valid && out_free;
    assign s1_free  = !r_s1_valid || out_free;
    assign o_stall  = !s1_free;
    assign accept   = i_valid && s1_free;

    // Front end: row and column tracking at accept time
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    t_filter          r_filter;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    t_filter          n_filter;

    logic             is_pixel;
    logic [COL_W-1:0] col_m1;
    logic [COL_W-1:0] x;
    logic             row_end;
    logic             last_row;
    logic [ROW_W:0]   row_p1;
    t_filter          filt_dec;
    t_pix_word        pw_in;
    logic [AW+COL_W-1:0] x_ext;
    logic [AW-1:0]    rd_addr;

    always_comb begin
        case (i_data_byte)
            PNG_FILTER_SUB:   filt_dec = FLT_SUB;
            PNG_FILTER_UP:    filt_dec = FLT_UP;
            PNG_FILTER_AVG:   filt_dec = FLT_AVG;
            PNG_FILTER_PAETH: filt_dec = FLT_PAETH;
            default:          filt_dec = FLT_NONE;
        endcase
    end

    always_comb begin
        is_pixel = (r_col != '0);
        col_m1   = r_col - COL_W'(1);
        x        = (col_m1 >= rb_eff) ? (rb_eff - COL_W'(1)) : col_m1;
        row_end  = (r_col >= rb_eff);
        row_p1   = {1'b0, r_row} + (ROW_W+1)'(1);
        last_row = (row_p1 >= {1'b0, rc_eff});
        x_ext    = {{AW{1'b0}}, x};
        rd_addr  = x_ext[AW-1:0];

        pw_in.data       = i_data_byte;
        pw_in.filter     = r_filter;
        pw_in.has_left   = (x >= {{(COL_W-BPP_W){1'b0}}, bpp_eff});
        pw_in.has_upper  = (r_row != '0);
        pw_in.stride_sel = 2'(bpp_eff - BPP_W'(1));
        pw_in.row_end    = row_end;
        pw_in.image_end  = row_end && last_row;

        n_col    = r_col;
        n_row    = r_row;
        n_filter = r_filter;
        if (accept) begin
            if (!is_pixel) begin
                n_filter = filt_dec;
                n_col    = COL_W'(1);
            end else if (row_end) begin
                n_col = '0;
                n_row = last_row ? '0 : row_p1[ROW_W-1:0];
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_filter <= FLT_NONE;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_filter <= n_filter;
        end
    end

    // Line store holding the previous reconstructed row
    logic [BYTE_W-1:0] mem [MAX_ROW_BYTES];
    logic [BYTE_W-1:0] r_mem_q;
    logic [AW-1:0]     r_wr_addr;
    logic [BYTE_W-1:0] pix;
    logic              rd_en;

    assign rd_en = accept && is_pixel;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            mem[r_wr_addr] <= pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    // Forward a write that lands on the column being read in the same cycle.
    logic              r_fwd_hit;
    logic [BYTE_W-1:0] r_fwd_data;
    t_pix_word         r_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (rd_en) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= s1_adv && (r_wr_addr == rd_addr);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1       <= pw_in;
            r_wr_addr  <= rd_addr;
            r_fwd_data <= pix;
        end
    end

    // Compute stage: reconstruct the byte from left, upper and upper-left.
    logic [31:0]       r_left_hist;
    logic [31:0]       r_upper_hist;
    logic [BYTE_W-1:0] pa;
    logic [BYTE_W-1:0] pb;
    logic [BYTE_W-1:0] pc;
    logic [BYTE_W-1:0] left_sel;
    logic [BYTE_W-1:0] upleft_sel;
    logic [BYTE_W:0]   avg_sum;
    logic [BYTE_W-1:0] pred;

    always_comb begin
        case (r_s1.stride_sel)
            2'd0: begin
                left_sel   = r_left_hist[7:0];
                upleft_sel = r_upper_hist[7:0];
            end
            2'd1: begin
                left_sel   = r_left_hist[15:8];
                upleft_sel = r_upper_hist[15:8];
            end
            2'd2: begin
                left_sel   = r_left_hist[23:16];
                upleft_sel = r_upper_hist[23:16];
            end
            default: begin
                left_sel   = r_left_hist[31:24];
                upleft_sel = r_upper_hist[31:24];
            end
        endcase
        pa = r_s1.has_left ? left_sel : '0;
        if (r_s1.has_upper) begin
            pb = r_fwd_hit ? r_fwd_data : r_mem_q;
            pc = r_s1.has_left ? upleft_sel : '0;
        end else begin
            pb = '0;
            pc = '0;
        end
        avg_sum = {1'b0, pa} + {1'b0, pb};
        case (r_s1.filter)
            FLT_SUB:   pred = pa;
            FLT_UP:    pred = pb;
            FLT_AVG:   pred = avg_sum[BYTE_W:1];
            FLT_PAETH: pred = paeth_pred(pa, pb, pc);
            default:   pred = '0;
        endcase
        pix = r_s1.data + pred;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_hist  <= '0;
            r_upper_hist <= '0;
        end else if (s1_adv) begin
            r_left_hist  <= {r_left_hist[23:0], pix};
            r_upper_hist <= {r_upper_hist[23:0], pb};
        end
    end

    // Output register
    logic [BYTE_W-1:0] r_out_pixel;
    logic              r_out_row_end;
    logic              r_out_image_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pixel     <= pix;
            r_out_row_end   <= r_s1.row_end;
            r_out_image_end <= r_s1.image_end;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pixel_byte = r_out_pixel;
    assign o_row_end    = r_out_row_end;
    assign o_image_end  = r_out_image_end;

endmodule

`default_nettype wire

// ----- verif/tb_png_scanline_unfilter.sv -----
// Self-checking testbench for the PNG scanline unfilter: directed table, then random rows.
module tb_png_scanline_unfilter;
    import psu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LINE_DEPTH   = 8192;
    localparam int          CLK_PERIOD   = 12;
    localparam int          LIMIT_CYCLES = 1_500_000;
    localparam int          RANDOM_WORDS = 900;
    localparam int          QUIET_FROM   = 780;
    localparam int          DRAIN_PAUSE  = 4;
    localparam int          PLAN_ROWS    = 30;
    // Index with no register behind it; writes to it must change nothing.
    localparam logic [1:0]  CFG_SPARE    = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel;
        logic              row_end;
        logic              image_end;
    } t_pix_result;

    typedef struct packed {
        logic              is_cfg;
        logic [1:0]        idx;
        logic [CFG_W-1:0]  val;
        logic [BYTE_W-1:0] data;
        logic              known;
        t_pix_result       want;
    } t_plan_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [BYTE_W-1:0] o_pixel_byte;
    logic              o_row_end;
    logic              o_image_end;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    // Unfilter predictor state.
    logic [BYTE_W-1:0] line_store [LINE_DEPTH];
    logic [31:0]       left_bytes = '0;
    logic [31:0]       upper_left_bytes = '0;
    int unsigned       next_col = 0;
    int unsigned       cur_row = 0;
    logic [7:0]        row_filter = '0;
    int unsigned       stored_len = 0;
    logic [2:0]        reg_stride = 3'd4;
    logic [13:0]       reg_row_len = 14'd8192;
    logic [15:0]       reg_row_total = 16'd1;

    t_pix_result       pending_pixels [$];
    t_pix_result       oldest;
    t_plan_row         directed_plan [PLAN_ROWS];

    int                fault_count = 0;
    int                words_in = 0;
    int                words_out = 0;
    int                rows_done = 0;
    int                reg_writes = 0;
    int                stall_left = 0;
    bit                gaps_on = 1'b1;
    bit                stalls_on = 1'b1;

    png_scanline_unfilter #(
        .MAX_ROW_BYTES(LINE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel_byte(o_pixel_byte),
        .o_row_end   (o_row_end),
        .o_image_end (o_image_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    task automatic log_fault(input string what);
        fault_count++;
        if (fault_count <= 10) begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
    endtask

    function automatic int unsigned eff_row_len(input logic [13:0] v);
        if (v == 0) return 1;
        if (v > LINE_DEPTH) return LINE_DEPTH;
        return v;
    endfunction

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        int est;
        int da;
        int db;
        int dc;
        est = int'(a) + int'(b) - int'(c);
        da = est - int'(a);
        db = est - int'(b);
        dc = est - int'(c);
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc) return a;
        if (db <= dc) return b;
        return c;
    endfunction

    // Advances the predictor by one input word and gives the output word it causes, if any.
    task automatic unfilter_byte(input logic [7:0] d, output bit emits, output t_pix_result res);
        int unsigned stride;
        int unsigned row_len;
        int unsigned rows;
        int unsigned x;
        logic [7:0]  left;
        logic [7:0]  up;
        logic [7:0]  up_left;
        logic [7:0]  pix;
        res = '0;
        emits = 1'b0;
        if (next_col == 0) begin
            row_filter = d;
            left_bytes = '0;
            upper_left_bytes = '0;
            next_col = 1;
        end else begin
            stride = (reg_stride == 0) ? 1 : ((reg_stride > 4) ? 4 : reg_stride);
            row_len = eff_row_len(reg_row_len);
            rows = (reg_row_total == 0) ? 1 : reg_row_total;
            // A column past a shortened row folds onto the last column.
            x = (next_col - 1 >= row_len) ? row_len - 1 : next_col - 1;
            left = '0;
            up = '0;
            up_left = '0;
            if (x >= stride) left = 8'(left_bytes >> (8 * (stride - 1)));
            if (cur_row != 0) begin
                if (x >= stored_len) log_fault("stimulus read a line store entry never written");
                up = line_store[x];
                if (x >= stride) up_left = 8'(upper_left_bytes >> (8 * (stride - 1)));
            end
            case (row_filter)
                PNG_FILTER_SUB:   pix = d + left;
                PNG_FILTER_UP:    pix = d + up;
                PNG_FILTER_AVG:   pix = d + 8'((9'(left) + 9'(up)) >> 1);
                PNG_FILTER_PAETH: pix = d + paeth_pick(left, up, up_left);
                default:          pix = d;
            endcase
            line_store[x] = pix;
            if (x + 1 > stored_len) stored_len = x + 1;
            left_bytes = {left_bytes[23:0], pix};
            upper_left_bytes = {upper_left_bytes[23:0], up};
            res.pixel = pix;
            res.row_end = (next_col >= row_len);
            res.image_end = res.row_end && (cur_row + 1 >= rows);
            emits = 1'b1;
            if (res.row_end) begin
                rows_done++;
                next_col = 0;
                cur_row = (cur_row + 1 >= rows) ? 0 : cur_row + 1;
            end else begin
                next_col++;
            end
        end
    endtask

    // Sends one input word; a known expectation replaces the predicted one when given.
    task automatic send_word(input logic [7:0] d, input bit known, input t_pix_result want,
                             output bit row_done);
        bit          emits;
        t_pix_result res;
        t_pix_result item;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= d;
        do @(posedge i_clk); while (o_stall);
        words_in++;
        unfilter_byte(d, emits, res);
        if (emits) begin
            item = known ? want : res;
            pending_pixels = {pending_pixels, item};
        end
        row_done = emits && res.row_end;
    endtask

    task automatic drain_outputs();
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        // A filter word gives no output; it only sets the filter register when accepted.
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        drain_outputs();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_BPP:       reg_stride = val[2:0];
            CFG_ROW_BYTES: reg_row_len = val[13:0];
            CFG_ROW_COUNT: reg_row_total = val[15:0];
            default:       ;
        endcase
    endtask

    function automatic logic [7:0] choose_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] choose_filter();
        if ($urandom_range(0, 9) < 8) begin
            return 8'($urandom_range(PNG_FILTER_NONE, PNG_FILTER_PAETH));
        end
        return 8'($urandom_range(PNG_FILTER_PAETH + 1, 255));
    endfunction

    task automatic reconfigure();
        logic [CFG_W-1:0] v;
        int unsigned      len;
        if ($urandom_range(0, 1) != 0) begin
            v = 16'($urandom);
            v[2:0] = 3'($urandom_range(0, 7));
            write_reg(CFG_BPP, v);
        end
        if ($urandom_range(0, 1) != 0) begin
            case ($urandom_range(0, 19))
                0:       len = 0;
                1:       len = $urandom_range(25, 80);
                default: len = $urandom_range(1, 24);
            endcase
            // Past the first row the upper row is read, so it may not outgrow the stored row.
            if (cur_row != 0 && eff_row_len(14'(len)) > stored_len) begin
                len = $urandom_range(1, stored_len);
            end
            v = 16'($urandom);
            v[13:0] = 14'(len);
            write_reg(CFG_ROW_BYTES, v);
        end
        if ($urandom_range(0, 1) != 0) begin
            case ($urandom_range(0, 9))
                0:       v = 16'd0;
                1:       v = 16'hFFFF;
                2:       v = 16'($urandom_range(1, 65535));
                default: v = 16'($urandom_range(1, 6));
            endcase
            write_reg(CFG_ROW_COUNT, v);
        end
    endtask

    function automatic t_plan_row plan_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        t_plan_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    function automatic t_plan_row plan_word(input logic [7:0] d);
        t_plan_row r;
        r = '0;
        r.data = d;
        return r;
    endfunction

    function automatic t_plan_row plan_known(input logic [7:0] d, input logic [7:0] pix,
                                             input bit re, input bit ie);
        t_plan_row r;
        r = '0;
        r.data = d;
        r.known = 1'b1;
        r.want = '{pixel: pix, row_end: re, image_end: ie};
        return r;
    endfunction

    // Receiver stalls in bursts.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(1, 14) - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            words_out++;
            if (pending_pixels.size() == 0) begin
                log_fault($sformatf("unexpected output word: pixel=%02h row_end=%0b image_end=%0b",
                                    o_pixel_byte, o_row_end, o_image_end));
            end else begin
                oldest = pending_pixels.pop_front();
                if (o_pixel_byte !== oldest.pixel || o_row_end !== oldest.row_end ||
                    o_image_end !== oldest.image_end) begin
                    log_fault($sformatf({"word %0d: expected pixel=%02h row_end=%0b ",
                                         "image_end=%0b, got pixel=%02h row_end=%0b ",
                                         "image_end=%0b"},
                                        words_out, oldest.pixel, oldest.row_end,
                                        oldest.image_end, o_pixel_byte, o_row_end, o_image_end));
                end
            end
        end
    end

    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("png_scanline_unfilter regression: fail");
        $finish;
    end

    initial begin
        bit ended;
        int random_words;
        int rows_wanted;
        int cut_at;
        int sent;

        random_words = 0;
        directed_plan = '{
            // Reset settings: a None row passes words through, no row end yet.
            plan_word(PNG_FILTER_NONE),
            plan_known(8'h00, 8'h00, 1'b0, 1'b0),
            plan_known(8'hFF, 8'hFF, 1'b0, 1'b0),
            plan_known(8'h5A, 8'h5A, 1'b0, 1'b0),
            // Row shortened below the current column: the next word ends row and image.
            plan_reg(CFG_ROW_BYTES, 16'd2),
            plan_known(8'h33, 8'h33, 1'b1, 1'b1),
            // Zero row count, zero stride and zero row length all act as one.
            plan_reg(CFG_ROW_COUNT, 16'd0),
            plan_reg(CFG_BPP, 16'd0),
            plan_reg(CFG_ROW_BYTES, 16'd0),
            plan_reg(CFG_SPARE, 16'hFFFF),
            plan_word(PNG_FILTER_SUB),
            plan_known(8'h80, 8'h80, 1'b1, 1'b1),
            // One short row per filter type; each row after the first reads the row above.
            plan_reg(CFG_ROW_COUNT, 16'hFFFF),
            plan_reg(CFG_BPP, 16'd1),
            plan_reg(CFG_ROW_BYTES, 16'd2),
            plan_word(PNG_FILTER_SUB),
            plan_word(8'h10),
            plan_word(8'hF8),
            plan_word(PNG_FILTER_UP),
            plan_word(8'hF0),
            plan_word(8'h01),
            plan_word(PNG_FILTER_AVG),
            plan_word(8'h7F),
            plan_word(8'h80),
            plan_word(PNG_FILTER_PAETH),
            plan_word(8'hFF),
            plan_word(8'h01),
            // An unknown filter type passes words through.
            plan_word(PNG_FILTER_PAETH + 8'd1),
            plan_known(8'hC3, 8'hC3, 1'b0, 1'b0),
            plan_known(8'h3C, 8'h3C, 1'b1, 1'b0)
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_cfg) begin
                write_reg(directed_plan[i].idx, directed_plan[i].val);
            end else begin
                send_word(directed_plan[i].data, directed_plan[i].known, directed_plan[i].want,
                          ended);
            end
        end

        while (random_words < RANDOM_WORDS) begin
            if (random_words >= QUIET_FROM) begin
                gaps_on = 1'b0;
                stalls_on = 1'b0;
            end else begin
                gaps_on = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end

            if ($urandom_range(0, 2) != 0) begin
                reconfigure();
            end else if ($urandom_range(0, 3) == 0) begin
                drain_outputs();
            end

            // Mostly whole rows; now and then the phase breaks off inside a row.
            rows_wanted = $urandom_range(1, 6);
            cut_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) : 0;
            sent = 0;
            while (rows_wanted > 0 && !(cut_at != 0 && sent == cut_at)) begin
                send_word((next_col == 0) ? choose_filter() : choose_pixel(), 1'b0, '0, ended);
                sent++;
                random_words++;
                if (ended) rows_wanted--;
            end
        end

        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d input words over %0d rows with %0d register writes;",
                 words_in, rows_done, reg_writes);
        $display("%0d output words were compared against the predictor.", words_out);
        if (fault_count == 0) begin
            $display("png_scanline_unfilter regression: pass");
        end else begin
            $display("png_scanline_unfilter regression: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/psu_pkg.sv
rtl/png_scanline_unfilter.sv
verif/tb_png_scanline_unfilter.sv
